@@ design/tpdfdr_pkg.sv @@
// ----------------------------------------------------------------------------
// TPDF dither requantizer package
// Shared widths, constants and the dither generator step function.
// ----------------------------------------------------------------------------
package tpdfdr_pkg;

    localparam int WORD_W   = 32;  // raw capture word width
    localparam int SAMPLE_W = 16;  // output sample width
    localparam int S24_W    = 24;  // extracted input sample width
    localparam int SUM_W    = 26;  // sample + dither + rounding, no overflow
    localparam int SHIFT    = 8;   // requantization shift (24 -> 16 bits)
    localparam int Q_W      = SUM_W - SHIFT;

    localparam logic [31:0] DITHER_SEED = 32'h1f2e3d4c;
    localparam logic signed [SUM_W-1:0] ROUND_OFFSET = 26'sd128;
    localparam logic signed [SAMPLE_W-1:0] SAT_HIGH = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAT_LOW  = -16'sd32768;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

@@ design/tpdfdr_datapath.sv @@
// ----------------------------------------------------------------------------
// TPDF dither requantizer datapath
// Extracts the 24-bit sample, adds triangular dither and rounding, shifts
// down to 16 bits with saturation, and returns the advanced generator state.
// ----------------------------------------------------------------------------
module tpdfdr_datapath (
    input  logic [tpdfdr_pkg::WORD_W-1:0]          capture_word,
    input  logic [31:0]                            gen_state,
    output logic [31:0]                            gen_state_next,
    output logic signed [tpdfdr_pkg::SAMPLE_W-1:0] sample_out
);
    import tpdfdr_pkg::*;

    logic [31:0]                draw1;
    logic [31:0]                draw2;
    logic signed [8:0]          dither;
    logic signed [S24_W-1:0]    s24;
    logic signed [SUM_W-1:0]    sum;
    logic signed [Q_W-1:0]      q;

    always_comb begin
        draw1          = xorshift32(gen_state);
        draw2          = xorshift32(draw1);
        gen_state_next = draw2;

        // Top byte of the first draw minus top byte of the second: -255..255.
        dither = $signed({1'b0, draw1[31:24]}) - $signed({1'b0, draw2[31:24]});

        // Bit 31 is the serial-port delay bit; bits 6..0 are below the sample.
        s24 = $signed(capture_word[30:7]);

        sum = {{(SUM_W-S24_W){s24[S24_W-1]}}, s24}
            + {{(SUM_W-9){dither[8]}}, dither}
            + ROUND_OFFSET;

        // Arithmetic shift right is a plain slice of the signed sum.
        q = sum[SUM_W-1:SHIFT];

        if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
            sample_out = q[SAMPLE_W-1:0];
        end else if (q[Q_W-1]) begin
            sample_out = SAT_LOW;
        end else begin
            sample_out = SAT_HIGH;
        end
    end

endmodule

@@ design/tpdf_dither_requantizer.sv @@
// ----------------------------------------------------------------------------
// TPDF dither requantizer, 24 to 16 bits
// Requantizes raw serial-audio capture words to dithered 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one raw 32-bit capture word per beat; the 24-bit
//   sample sits in bits 30..7. The master channel delivers one signed 16-bit
//   sample per input beat, in order.
//   The block is a two-register pipeline: an input register, then the
//   dither/round/saturate logic, then the output register. An accepted beat
//   waits in the input register until the output register is free, and then
//   moves into it and raises m_tvalid. One beat is accepted every cycle while
//   the output side keeps taking results.
//   The dither generator advances by two steps for each beat that moves from
//   the input register to the output register, so its sequence follows the
//   beat order regardless of gaps.
//   Reset clears both valid flags and reloads the generator seed. When the
//   receiver stalls, the output register holds its beat, the input register
//   fills, and s_tready then drops until the output beat is taken.
// ----------------------------------------------------------------------------
module tpdf_dither_requantizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tpdfdr_pkg::WORD_W-1:0]     s_tdata,   // [31:0] capture_word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tpdfdr_pkg::SAMPLE_W-1:0]   m_tdata    // [15:0] sample_out
);
    import tpdfdr_pkg::*;

    logic                       in_valid_reg;
    logic [WORD_W-1:0]          in_word_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic [31:0]                gen_reg;
    logic [31:0]                gen_next;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_ready;
    logic                       advance;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    tpdfdr_datapath u_datapath (
        .capture_word   (in_word_reg),
        .gen_state      (gen_reg),
        .gen_state_next (gen_next),
        .sample_out     (sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_reg       <= DITHER_SEED;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                gen_reg <= gen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= sample;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
